/* hdl/tslf_pkg.sv */
`default_nettype none

package tslf_pkg;

    // Configuration port widths and register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

    // Line numbering modes.
    localparam logic [1:0] NUM_MODE_ALL      = 2'd1;
    localparam logic [1:0] NUM_MODE_NONBLANK = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UPPER_I = 8'h49;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CARET_OFFSET = 8'h40;

    // One or two output bytes for a single text byte.
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } fmt_pair_t;

    // Work handed from the front to the back for one request.
    typedef struct packed {
        logic      held_en;
        fmt_pair_t held;
        logic      num_en;
        logic      tail_en;
        fmt_pair_t tail;
    } fmt_cmd_t;

    // Output segment currently being emitted by the back.
    typedef enum logic [1:0] {
        SEG_HELD,
        SEG_NUM,
        SEG_TAIL
    } seg_t;

    // Visible form of one byte under the display options.
    function automatic fmt_pair_t format_byte(
        input logic [7:0] b,
        input logic       show_ends,
        input logic       show_tabs,
        input logic       show_np
    );
        fmt_pair_t r;
        logic      ctrl;
        ctrl = (b < CH_TAB) || ((b >= CH_VT) && (b < CH_SPACE)) || (b == CH_DEL);
        r.two = 1'b0;
        r.b0  = b;
        r.b1  = b;
        priority if (show_ends && (b == CH_NL))
        begin
            r.two = 1'b1;
            r.b0  = CH_DOLLAR;
            r.b1  = CH_NL;
        end
        else if (show_tabs && (b == CH_TAB))
        begin
            r.two = 1'b1;
            r.b0  = CH_CARET;
            r.b1  = CH_UPPER_I;
        end
        else if (show_np && ctrl)
        begin
            r.two = 1'b1;
            r.b0  = CH_CARET;
            r.b1  = (b == CH_DEL) ? CH_QMARK : (b + CARET_OFFSET);
        end
        else
        begin
            r.two = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/tslf_front.sv */
`default_nettype none

module tslf_front
    import tslf_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      end_of_file,
    input  wire logic                      q_full,
    output logic                           push,
    output fmt_cmd_t                       cmd,
    output logic [4*NUMBER_DIGITS-1:0]     num
);

    localparam int BW = 4 * NUMBER_DIGITS;

    logic [1:0]    number_mode_reg;
    logic          squeeze_reg;
    logic          show_ends_reg;
    logic          show_tabs_reg;
    logic          show_np_reg;

    logic [7:0]    held_byte_reg, held_byte_next;
    logic          held_valid_reg, held_valid_next;
    logic [1:0]    blank_run_reg, blank_run_next;
    logic [BW-1:0] line_num_reg, line_num_next;

    logic          accept;
    logic          want_num;
    logic          squeeze_pair;
    logic [1:0]    blank_inc;

    // Saturating BCD increment of the line counter.
    function automatic logic [BW-1:0] bcd_inc_sat(input logic [BW-1:0] v);
        logic [BW-1:0] r;
        logic [3:0]    dig;
        logic          carry;
        logic          all9;
        r     = v;
        carry = 1'b1;
        all9  = 1'b1;
        for (int k = 0; k < NUMBER_DIGITS; k++)
        begin
            dig = v[4*k +: 4];
            if (carry)
            begin
                r[4*k +: 4] = (dig >= 4'd9) ? 4'd0 : (dig + 4'd1);
            end
            carry = carry && (dig >= 4'd9);
            all9  = all9 && (dig == 4'd9);
        end
        return all9 ? v : r;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_mode_reg <= '0;
            squeeze_reg     <= 1'b0;
            show_ends_reg   <= 1'b0;
            show_tabs_reg   <= 1'b0;
            show_np_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUMBER_MODE:      number_mode_reg <= cfg_data[1:0];
                CFG_SQUEEZE_BLANK:    squeeze_reg     <= cfg_data[0];
                CFG_SHOW_ENDS:        show_ends_reg   <= cfg_data[0];
                CFG_SHOW_TABS:        show_tabs_reg   <= cfg_data[0];
                CFG_SHOW_NONPRINTING: show_np_reg     <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Classify the request into held, number and tail segments.
    always_comb
    begin
        want_num = (number_mode_reg == NUM_MODE_ALL) ||
                   ((number_mode_reg == NUM_MODE_NONBLANK) && (data_byte != CH_NL));
        squeeze_pair = squeeze_reg && (held_byte_reg == CH_NL) && (data_byte == CH_NL);
        blank_inc = (blank_run_reg == 2'd2) ? 2'd2 : (blank_run_reg + 2'd1);

        cmd.held    = format_byte(held_byte_reg, show_ends_reg, show_tabs_reg, show_np_reg);
        cmd.tail    = format_byte(data_byte, show_ends_reg, show_tabs_reg, show_np_reg);
        cmd.tail_en = end_of_file;
        blank_run_next = blank_run_reg;

        if (!held_valid_reg)
        begin
            cmd.held_en = 1'b0;
            cmd.num_en  = want_num;
        end
        else if (squeeze_pair)
        begin
            blank_run_next = blank_inc;
            cmd.held_en    = (blank_inc <= 2'd1);
            cmd.num_en     = (blank_inc <= 2'd1) && want_num;
        end
        else
        begin
            blank_run_next = 2'd0;
            cmd.held_en    = 1'b1;
            cmd.num_en     = (held_byte_reg == CH_NL) && want_num;
        end

        num           = line_num_reg;
        line_num_next = cmd.num_en ? bcd_inc_sat(line_num_reg) : line_num_reg;

        // End of file returns everything to file-start values.
        if (end_of_file)
        begin
            held_byte_next  = 8'h00;
            held_valid_next = 1'b0;
            blank_run_next  = 2'd1;
            line_num_next   = BW'(1);
        end
        else
        begin
            held_byte_next  = data_byte;
            held_valid_next = 1'b1;
        end

        push = accept && (cmd.held_en || cmd.num_en || cmd.tail_en);
    end

    // Lookahead and line state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            blank_run_reg  <= 2'd1;
            line_num_reg   <= BW'(1);
        end
        else if (accept)
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            blank_run_reg  <= blank_run_next;
            line_num_reg   <= line_num_next;
        end
    end

    // A request that ends a file leaves nothing held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_file) |=> !held_valid_reg)
        else $error("front: held byte survives end of file");

    // Blank run never goes past two.
    assert property (@(posedge clk) disable iff (!rst_n)
        blank_run_reg != 2'd3)
        else $error("front: blank run out of range");

endmodule

`default_nettype wire

/* hdl/tslf_queue.sv */
`default_nettype none

module tslf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : (wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : (rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue: write while full");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue: read while empty");

endmodule

`default_nettype wire

/* hdl/tslf_back.sv */
`default_nettype none

module tslf_back
    import tslf_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_empty,
    input  wire fmt_cmd_t                   head,
    input  wire logic [4*NUMBER_DIGITS-1:0] head_num,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [7:0]                      out_byte,
    output logic                            last_of_run
);

    localparam int IW = $clog2(NUMBER_DIGITS + 1);
    localparam logic [IW-1:0] TAB_IDX = IW'(NUMBER_DIGITS);
    localparam logic [IW-1:0] LSD_IDX = IW'(NUMBER_DIGITS - 1);

    seg_t          seg_reg, seg_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          seen_reg, seen_next;
    logic          fresh_reg, fresh_next;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          last_reg;

    seg_t          first_seg, eff_seg, follow_seg;
    logic [IW-1:0] eff_idx;
    logic          eff_seen;
    logic [3:0]    digit;
    logic [7:0]    cur_byte;
    logic          seg_last;
    logic          more;
    logic          item_last;
    logic          advance;

    assign advance = !q_empty && (!out_valid_reg || !out_stall);
    assign pop     = advance && item_last;

    // Byte selection for the current position in the head entry.
    always_comb
    begin
        first_seg = head.held_en ? SEG_HELD : (head.num_en ? SEG_NUM : SEG_TAIL);
        eff_seg   = fresh_reg ? first_seg : seg_reg;
        eff_idx   = fresh_reg ? '0 : idx_reg;
        eff_seen  = fresh_reg ? 1'b0 : seen_reg;

        digit = 4'd0;
        for (int k = 0; k < NUMBER_DIGITS; k++)
        begin
            if (eff_idx == IW'(NUMBER_DIGITS - 1 - k))
            begin
                digit = head_num[4*k +: 4];
            end
        end

        cur_byte   = head.tail.b0;
        seg_last   = 1'b1;
        more       = 1'b0;
        follow_seg = SEG_TAIL;
        unique case (eff_seg)
            SEG_HELD:
            begin
                cur_byte   = (eff_idx == '0) ? head.held.b0 : head.held.b1;
                seg_last   = !head.held.two || (eff_idx != '0);
                follow_seg = head.num_en ? SEG_NUM : SEG_TAIL;
                more       = head.num_en || head.tail_en;
            end
            SEG_NUM:
            begin
                // Leading zero digits show as spaces.
                if (eff_idx == TAB_IDX)
                begin
                    cur_byte = CH_TAB;
                end
                else if (eff_seen || (digit != 4'd0) || (eff_idx == LSD_IDX))
                begin
                    cur_byte = CH_ZERO | {4'h0, digit};
                end
                else
                begin
                    cur_byte = CH_SPACE;
                end
                seg_last   = (eff_idx == TAB_IDX);
                follow_seg = SEG_TAIL;
                more       = head.tail_en;
            end
            SEG_TAIL:
            begin
                cur_byte = (eff_idx == '0) ? head.tail.b0 : head.tail.b1;
                seg_last = !head.tail.two || (eff_idx != '0);
                more     = 1'b0;
            end
            default:
            begin
                seg_last = 1'b1;
                more     = 1'b0;
            end
        endcase
        item_last = seg_last && !more;
    end

    // Position within the head entry.
    always_comb
    begin
        seg_next   = seg_reg;
        idx_next   = idx_reg;
        seen_next  = seen_reg;
        fresh_next = fresh_reg;
        if (advance)
        begin
            priority if (item_last)
            begin
                fresh_next = 1'b1;
                seg_next   = SEG_HELD;
                idx_next   = '0;
                seen_next  = 1'b0;
            end
            else if (seg_last)
            begin
                fresh_next = 1'b0;
                seg_next   = follow_seg;
                idx_next   = '0;
                seen_next  = 1'b0;
            end
            else
            begin
                fresh_next = 1'b0;
                seg_next   = eff_seg;
                idx_next   = eff_idx + 1'b1;
                seen_next  = eff_seen || (digit != 4'd0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg   <= SEG_HELD;
            idx_reg   <= '0;
            seen_reg  <= 1'b0;
            fresh_reg <= 1'b1;
        end
        else
        begin
            seg_reg   <= seg_next;
            idx_reg   <= idx_next;
            seen_reg  <= seen_next;
            fresh_reg <= fresh_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            last_reg     <= item_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    // Retiring an entry puts its final byte, flagged, in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && last_reg))
        else $error("back: entry retired without a flagged final byte");

endmodule

`default_nettype wire

/* hdl/text_stream_line_formatter_unit.sv */
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------
// input    | in_valid / in_stall   | data_byte[7:0], end_of_file
// output   | out_valid / out_stall | out_byte[7:0], last_of_run
// config   | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[7:0]
//
// A request is taken whenever the command queue has room; the back drains
// each queued request at one output byte per cycle while out_stall is low.
// A queued request yields 1 to NUMBER_DIGITS+5 output bytes; its first
// result passes through the command queue and then the output register.
// Reset clears the lookahead and options and sets blank run and line counter to one.
// in_stall is high while the queue is full; out_stall freezes the output
// register and, through the queue, the front.

module text_stream_line_formatter_unit
    import tslf_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6,
    parameter int QUEUE_DEPTH   = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   end_of_file,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  out_byte,
    output logic                        last_of_run
);

    localparam int BW = 4 * NUMBER_DIGITS;
    localparam int QW = $bits(fmt_cmd_t) + BW;

    fmt_cmd_t      front_cmd, head_cmd;
    logic [BW-1:0] front_num, head_num;
    logic [QW-1:0] q_rdata;
    logic          q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    tslf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .q_full      (q_full),
        .push        (q_push),
        .cmd         (front_cmd),
        .num         (front_num)
    );

    tslf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({front_cmd, front_num}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign head_cmd = q_rdata[QW-1:BW];
    assign head_num = q_rdata[BW-1:0];

    tslf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head_cmd),
        .head_num    (head_num),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
